// ===== rtl/gan_pkg.sv =====
// Shared types, widths and constants for the gradient angle core.
// Holds the CORDIC arctangent table used by the top level and the square-root pipeline widths.
// No dependencies.
package gan_pkg;

   // Normalized vector components: magnitude in [2^14, 2^15], plus a sign bit.
   localparam int NORM_W       = 16;
   localparam int NORM_TOP_BIT = 15;
   localparam logic [NORM_W-1:0] NORM_HI = 16'h8000;
   localparam logic [NORM_W-1:0] NORM_LO = 16'h4000;
   localparam int COMP_S_W     = NORM_W + 1;

   // Product, dot product and cross product widths.
   localparam int PROD_W = 2 * COMP_S_W;
   localparam int DOT_W  = PROD_W;
   localparam int CABS_W = 32;
   localparam int CSQ_W  = 2 * CABS_W;

   // Square-root pipeline: one root bit per stage plus an input register.
   localparam int SQRT_W   = CSQ_W / 2;
   localparam int SQRT_LAT = SQRT_W + 1;

   // CORDIC datapath.
   localparam int XY_W         = 36;
   localparam int Z_W          = 32;
   localparam int ZTAB_BITS    = 30;
   localparam int CORDIC_STEPS = 28;
   localparam int CORDIC_IDX_W = 5;
   localparam logic [Z_W-1:0] Z_HALF = Z_W'(1) << (ZTAB_BITS - 1);

   typedef logic        [NORM_W-1:0]   norm_mag_type;
   typedef logic signed [COMP_S_W-1:0] comp_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [DOT_W-1:0]    dot_type;
   typedef logic        [CABS_W-1:0]   cabs_type;
   typedef logic        [CSQ_W-1:0]    csq_type;
   typedef logic        [SQRT_W-1:0]   root_type;
   typedef logic signed [XY_W-1:0]     xy_type;
   typedef logic signed [Z_W-1:0]      z_type;

   // atan(2^-i) / pi scaled by 2^30, rounded.
   function automatic z_type gan_atan(input logic [CORDIC_IDX_W-1:0] idx);
      z_type val;
      unique case (idx)
         5'd0:  val = 32'sd268435456;
         5'd1:  val = 32'sd158466703;
         5'd2:  val = 32'sd83729454;
         5'd3:  val = 32'sd42502378;
         5'd4:  val = 32'sd21333666;
         5'd5:  val = 32'sd10677233;
         5'd6:  val = 32'sd5339919;
         5'd7:  val = 32'sd2670123;
         5'd8:  val = 32'sd1335082;
         5'd9:  val = 32'sd667543;
         5'd10: val = 32'sd333772;
         5'd11: val = 32'sd166886;
         5'd12: val = 32'sd83443;
         5'd13: val = 32'sd41722;
         5'd14: val = 32'sd20861;
         5'd15: val = 32'sd10430;
         5'd16: val = 32'sd5215;
         5'd17: val = 32'sd2608;
         5'd18: val = 32'sd1304;
         5'd19: val = 32'sd652;
         5'd20: val = 32'sd326;
         5'd21: val = 32'sd163;
         5'd22: val = 32'sd81;
         5'd23: val = 32'sd41;
         5'd24: val = 32'sd20;
         5'd25: val = 32'sd10;
         5'd26: val = 32'sd5;
         5'd27: val = 32'sd3;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== rtl/gan_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit resolved per register stage.
// Depends on gan_pkg for widths; takes one word per cycle.
module gan_sqrt_pipe
   import gan_pkg::*;
(
   input  logic     clock,
   input  csq_type  radicand,
   output root_type root
);

   localparam int TW = CSQ_W + 1;

   csq_type  rem_ff  [SQRT_W];
   root_type root_ff [SQRT_W];
   root_type root_out_ff;

   // Input register.
   always_ff @(posedge clock) begin
      rem_ff[0]  <= radicand;
      root_ff[0] <= '0;
   end

   // Each stage tries one root bit: (root + 2^j)^2 - root^2 against the remainder.
   for (genvar k = 0; k < SQRT_W; k++) begin : g_stage
      localparam int J = SQRT_W - 1 - k;
      logic [TW-1:0] trial;
      logic          take;

      always_comb begin
         trial = (TW'(root_ff[k]) << (J + 1)) + (TW'(1) << (2 * J));
         take  = TW'(rem_ff[k]) >= trial;
      end

      if (k < SQRT_W - 1) begin : g_mid
         always_ff @(posedge clock) begin
            rem_ff[k+1]  <= take ? (rem_ff[k] - trial[CSQ_W-1:0]) : rem_ff[k];
            root_ff[k+1] <= take ? (root_ff[k] | (SQRT_W'(1) << J)) : root_ff[k];
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            root_out_ff <= take ? (root_ff[k] | (SQRT_W'(1) << J)) : root_ff[k];
         end
      end
   end

   assign root = root_out_ff;

endmodule

// ===== rtl/gradient_angle_normalized_core.sv =====
// Throughput: one word per clock; busy is never raised and every stage advances each cycle.
// The depth is set by the 32-stage square-root pipeline and the 28-stage CORDIC pipeline.
// Reset (synchronous, active high) clears all valid bits; data registers are not reset.
// Results cannot be stalled by the receiver, so no back-pressure path exists.
// Depends on gan_pkg and gan_sqrt_pipe.
module gradient_angle_normalized_core
   import gan_pkg::*;
#(
   parameter int COMP_WIDTH      = 16,
   parameter int ANGLE_FRAC_BITS = 15
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COMP_WIDTH-1:0] req_first_x,
   input  logic signed [COMP_WIDTH-1:0] req_first_y,
   input  logic signed [COMP_WIDTH-1:0] req_first_z,
   input  logic signed [COMP_WIDTH-1:0] req_second_x,
   input  logic signed [COMP_WIDTH-1:0] req_second_y,
   input  logic signed [COMP_WIDTH-1:0] req_second_z,
   output logic                         rsp_valid,
   output logic [ANGLE_FRAC_BITS:0]     rsp_angle_fraction,
   output logic                         rsp_degenerate
);

   localparam int PW       = $clog2(COMP_WIDTH);
   localparam int SH_W     = PW + 1;
   localparam int WIDE_W   = COMP_WIDTH + NORM_W;
   localparam int ROUND_SH = ZTAB_BITS - ANGLE_FRAC_BITS;
   localparam int OUT_W    = ANGLE_FRAC_BITS + 1;
   localparam int LATENCY  = 9 + SQRT_LAT + 1 + CORDIC_STEPS + 1;
   localparam logic [Z_W-1:0] ROUND_HALF = Z_W'(1) << (ROUND_SH - 1);
   localparam logic [Z_W-1:0] FULL_SCALE = Z_W'(1) << ANGLE_FRAC_BITS;

   // Index of the highest set bit.
   function automatic logic [PW-1:0] lead_one(input logic [COMP_WIDTH-1:0] v);
      logic [PW-1:0] p;
      p = '0;
      for (int i = 0; i < COMP_WIDTH; i++) begin
         if (v[i]) p = PW'(i);
      end
      return p;
   endfunction

   // The pipeline takes a word every cycle.
   assign busy = 1'b0;

   // Stage 1: magnitudes, signs and the largest magnitude of each vector.
   logic [COMP_WIDTH-1:0] req_comp [6];
   logic [COMP_WIDTH-1:0] s1_mag_in [6];
   logic [COMP_WIDTH-1:0] s1_top_in [2];
   logic [COMP_WIDTH-1:0] s1_mag_ff [6];
   logic [COMP_WIDTH-1:0] s1_top_ff [2];
   logic [5:0]            s1_neg_ff;
   logic                  s1_valid_ff;

   assign req_comp[0] = req_first_x;
   assign req_comp[1] = req_first_y;
   assign req_comp[2] = req_first_z;
   assign req_comp[3] = req_second_x;
   assign req_comp[4] = req_second_y;
   assign req_comp[5] = req_second_z;

   always_comb begin
      for (int k = 0; k < 6; k++) begin
         s1_mag_in[k] = req_comp[k][COMP_WIDTH-1] ? (~req_comp[k] + 1'b1) : req_comp[k];
      end
      for (int v = 0; v < 2; v++) begin
         s1_top_in[v] = s1_mag_in[3*v];
         if (s1_mag_in[3*v+1] > s1_top_in[v]) s1_top_in[v] = s1_mag_in[3*v+1];
         if (s1_mag_in[3*v+2] > s1_top_in[v]) s1_top_in[v] = s1_mag_in[3*v+2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start;
      end
      for (int k = 0; k < 6; k++) begin
         s1_mag_ff[k] <= s1_mag_in[k];
         s1_neg_ff[k] <= req_comp[k][COMP_WIDTH-1];
      end
      s1_top_ff <= s1_top_in;
   end

   // Stage 2: leading-one position of each vector's top magnitude.
   logic [COMP_WIDTH-1:0] s2_mag_ff [6];
   logic [COMP_WIDTH-1:0] s2_top_ff [2];
   logic [PW-1:0]         s2_lead_ff [2];
   logic [5:0]            s2_neg_ff;
   logic                  s2_deg_ff;
   logic                  s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_mag_ff  <= s1_mag_ff;
      s2_top_ff  <= s1_top_ff;
      s2_neg_ff  <= s1_neg_ff;
      s2_deg_ff  <= (s1_top_ff[0] == '0) || (s1_top_ff[1] == '0);
      for (int v = 0; v < 2; v++) begin
         s2_lead_ff[v] <= lead_one(s1_top_ff[v]);
      end
   end

   // Stage 3: shift each vector so its top magnitude lands in [2^14, 2^15].
   // A right shift that leaves the top above 2^15 takes one more bit off.
   logic [SH_W-1:0]   s3_rsh [2];
   logic [SH_W-1:0]   s3_lsh [2];
   logic              s3_right [2];
   logic              s3_extra [2];
   logic [WIDE_W-1:0] s3_top_sh [2];
   logic [WIDE_W-1:0] s3_sh [6];
   norm_mag_type      s3_mag_ff [6];
   logic [5:0]        s3_neg_ff;
   logic              s3_deg_ff;
   logic              s3_valid_ff;

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         s3_right[v]  = int'(s2_lead_ff[v]) >= NORM_TOP_BIT;
         s3_rsh[v]    = SH_W'(s2_lead_ff[v]) - SH_W'(NORM_TOP_BIT);
         s3_lsh[v]    = SH_W'(NORM_TOP_BIT - 1) - SH_W'(s2_lead_ff[v]);
         s3_top_sh[v] = WIDE_W'(s2_top_ff[v]) >> s3_rsh[v];
         s3_extra[v]  = s3_right[v] && (s3_top_sh[v][NORM_W-1:0] != NORM_HI);
         for (int j = 0; j < 3; j++) begin
            if (s3_right[v]) begin
               s3_sh[3*v+j] = (WIDE_W'(s2_mag_ff[3*v+j]) >> s3_rsh[v]) >> s3_extra[v];
            end else begin
               s3_sh[3*v+j] = WIDE_W'(s2_mag_ff[3*v+j]) << s3_lsh[v];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      for (int k = 0; k < 6; k++) begin
         s3_mag_ff[k] <= s3_sh[k][NORM_W-1:0];
      end
      s3_neg_ff <= s2_neg_ff;
      s3_deg_ff <= s2_deg_ff;
   end

   // Stage 4: restore the signs.
   comp_type s4_comp_ff [6];
   logic     s4_deg_ff;
   logic     s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      for (int k = 0; k < 6; k++) begin
         s4_comp_ff[k] <= s3_neg_ff[k] ? -$signed({1'b0, s3_mag_ff[k]})
                                       : $signed({1'b0, s3_mag_ff[k]});
      end
      s4_deg_ff <= s3_deg_ff;
   end

   // Stage 5: all nine products of a first and a second component.
   prod_type s5_prod_ff [3][3];
   logic     s5_deg_ff;
   logic     s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s5_prod_ff[i][j] <= s4_comp_ff[i] * s4_comp_ff[3+j];
         end
      end
      s5_deg_ff <= s4_deg_ff;
   end

   // Stage 6: dot product and cross product components.
   dot_type  s6_dot_ff;
   prod_type s6_cross_ff [3];
   logic     s6_deg_ff;
   logic     s6_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
      s6_dot_ff      <= s5_prod_ff[0][0] + s5_prod_ff[1][1] + s5_prod_ff[2][2];
      s6_cross_ff[0] <= s5_prod_ff[1][2] - s5_prod_ff[2][1];
      s6_cross_ff[1] <= s5_prod_ff[2][0] - s5_prod_ff[0][2];
      s6_cross_ff[2] <= s5_prod_ff[0][1] - s5_prod_ff[1][0];
      s6_deg_ff      <= s5_deg_ff;
   end

   // Stage 7: cross product magnitudes fit 32 bits after normalization.
   prod_type s7_neg [3];
   cabs_type s7_cabs_ff [3];
   dot_type  s7_dot_ff;
   logic     s7_deg_ff;
   logic     s7_valid_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s7_neg[k] = -s6_cross_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
      for (int k = 0; k < 3; k++) begin
         s7_cabs_ff[k] <= s6_cross_ff[k][PROD_W-1] ? s7_neg[k][CABS_W-1:0]
                                                    : s6_cross_ff[k][CABS_W-1:0];
      end
      s7_dot_ff <= s6_dot_ff;
      s7_deg_ff <= s6_deg_ff;
   end

   // Stage 8: squares of the cross components.
   csq_type s8_sq_ff [3];
   dot_type s8_dot_ff;
   logic    s8_deg_ff;
   logic    s8_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
      for (int k = 0; k < 3; k++) begin
         s8_sq_ff[k] <= s7_cabs_ff[k] * s7_cabs_ff[k];
      end
      s8_dot_ff <= s7_dot_ff;
      s8_deg_ff <= s7_deg_ff;
   end

   // Stage 9: squared length of the cross product.
   csq_type s9_csq_ff;
   dot_type s9_dot_ff;
   logic    s9_deg_ff;
   logic    s9_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= s8_valid_ff;
      end
      s9_csq_ff <= s8_sq_ff[0] + s8_sq_ff[1] + s8_sq_ff[2];
      s9_dot_ff <= s8_dot_ff;
      s9_deg_ff <= s8_deg_ff;
   end

   // Square root of the cross length; the dot product waits alongside.
   root_type sqrt_root;
   dot_type  dly_dot_ff   [SQRT_LAT];
   logic     dly_deg_ff   [SQRT_LAT];
   logic     dly_valid_ff [SQRT_LAT];

   gan_sqrt_pipe u_sqrt (
      .clock    (clock),
      .radicand (s9_csq_ff),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_LAT; k++) dly_valid_ff[k] <= 1'b0;
      end else begin
         dly_valid_ff[0] <= s9_valid_ff;
         for (int k = 1; k < SQRT_LAT; k++) dly_valid_ff[k] <= dly_valid_ff[k-1];
      end
      dly_dot_ff[0] <= s9_dot_ff;
      dly_deg_ff[0] <= s9_deg_ff;
      for (int k = 1; k < SQRT_LAT; k++) begin
         dly_dot_ff[k] <= dly_dot_ff[k-1];
         dly_deg_ff[k] <= dly_deg_ff[k-1];
      end
   end

   // CORDIC input: a negative dot product is rotated by a quarter turn first.
   dot_type dot_last;
   xy_type  cr_x_ff [CORDIC_STEPS+1];
   xy_type  cr_y_ff [CORDIC_STEPS+1];
   z_type   cr_z_ff [CORDIC_STEPS+1];
   logic    cr_deg_ff [CORDIC_STEPS+1];
   logic    cr_valid_ff [CORDIC_STEPS+1];

   assign dot_last = dly_dot_ff[SQRT_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_valid_ff[0] <= 1'b0;
      end else begin
         cr_valid_ff[0] <= dly_valid_ff[SQRT_LAT-1];
      end
      cr_deg_ff[0] <= dly_deg_ff[SQRT_LAT-1];
      if (dot_last[DOT_W-1]) begin
         cr_x_ff[0] <= $signed({{(XY_W-SQRT_W){1'b0}}, sqrt_root});
         cr_y_ff[0] <= -$signed({{(XY_W-DOT_W){dot_last[DOT_W-1]}}, dot_last});
         cr_z_ff[0] <= $signed(Z_HALF);
      end else begin
         cr_x_ff[0] <= $signed({{(XY_W-DOT_W){dot_last[DOT_W-1]}}, dot_last});
         cr_y_ff[0] <= $signed({{(XY_W-SQRT_W){1'b0}}, sqrt_root});
         cr_z_ff[0] <= '0;
      end
   end

   // CORDIC vectoring: one rotation per stage drives y toward zero.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      xy_type x_sh;
      xy_type y_sh;
      z_type  step;
      logic   y_pos;

      always_comb begin
         x_sh  = cr_x_ff[i] >>> i;
         y_sh  = cr_y_ff[i] >>> i;
         step  = gan_atan(CORDIC_IDX_W'(i));
         y_pos = !cr_y_ff[i][XY_W-1] && (cr_y_ff[i] != '0);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cr_valid_ff[i+1] <= 1'b0;
         end else begin
            cr_valid_ff[i+1] <= cr_valid_ff[i];
         end
         cr_deg_ff[i+1] <= cr_deg_ff[i];
         if (y_pos) begin
            cr_x_ff[i+1] <= cr_x_ff[i] + y_sh;
            cr_y_ff[i+1] <= cr_y_ff[i] - x_sh;
            cr_z_ff[i+1] <= cr_z_ff[i] + step;
         end else begin
            cr_x_ff[i+1] <= cr_x_ff[i] - y_sh;
            cr_y_ff[i+1] <= cr_y_ff[i] + x_sh;
            cr_z_ff[i+1] <= cr_z_ff[i] - step;
         end
      end
   end

   // Output: clamp at zero, round half up to the output precision, clamp at one; a degenerate word gives zero.
   z_type          z_last;
   logic [Z_W-1:0] z_clamp;
   logic [Z_W-1:0] z_round;
   logic [Z_W-1:0] q_scaled;
   logic [OUT_W-1:0] angle_in;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_angle_ff;
   logic             rsp_deg_ff;

   always_comb begin
      z_last   = cr_z_ff[CORDIC_STEPS];
      z_clamp  = z_last[Z_W-1] ? '0 : z_last;
      z_round  = z_clamp + ROUND_HALF;
      q_scaled = z_round >> ROUND_SH;
      if (cr_deg_ff[CORDIC_STEPS]) begin
         angle_in = '0;
      end else if (q_scaled > FULL_SCALE) begin
         angle_in = FULL_SCALE[OUT_W-1:0];
      end else begin
         angle_in = q_scaled[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cr_valid_ff[CORDIC_STEPS];
      end
      rsp_angle_ff <= angle_in;
      rsp_deg_ff   <= cr_deg_ff[CORDIC_STEPS];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_angle_fraction = rsp_angle_ff;
   assign rsp_degenerate     = rsp_deg_ff;

   // Every accepted word produces exactly one result after the fixed latency.
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word produced no result");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("result without a matching accepted word");

   // Normalized vectors keep their top magnitude within [2^14, 2^15].
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !s3_deg_ff) |->
         ((s3_mag_ff[0] | s3_mag_ff[1] | s3_mag_ff[2]) >= NORM_LO) &&
         ((s3_mag_ff[3] | s3_mag_ff[4] | s3_mag_ff[5]) >= NORM_LO) &&
         (s3_mag_ff[0] <= NORM_HI) && (s3_mag_ff[1] <= NORM_HI) &&
         (s3_mag_ff[2] <= NORM_HI) && (s3_mag_ff[3] <= NORM_HI) &&
         (s3_mag_ff[4] <= NORM_HI) && (s3_mag_ff[5] <= NORM_HI))
      else $error("normalization left a vector out of range");

   // The angle never exceeds one half turn, and a zero vector gives angle zero.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (Z_W'(rsp_angle_fraction) <= FULL_SCALE) &&
                    (!rsp_degenerate || (rsp_angle_fraction == '0)))
      else $error("angle out of range");

endmodule
